FILE: rtl/core/gn2d_pkg.sv
// gn2d_pkg: shared types, constants and the gradient function of the 2d noise block
package gn2d_pkg;

  localparam int PERM_AW = 8;
  localparam int QB      = 24;

  localparam logic [31:0] LCG_MUL      = 32'd1664525;
  localparam logic [31:0] LCG_ADD      = 32'd1013904223;
  localparam logic [31:0] SEED_DEFAULT = 32'hdeadbeef;

  localparam logic signed [23:0] SKEW_F2 = 24'sd6140887;
  localparam logic signed [22:0] SKEW_G2 = 23'sd3545443;

  localparam logic signed [31:0] ONE_Q     = 32'sd16777216;
  localparam logic signed [31:0] HALF_Q    = 32'sd8388608;
  localparam logic signed [31:0] TEN_Q     = 32'sd167772160;
  localparam logic signed [31:0] FIFTEEN_Q = 32'sd251658240;

  localparam logic OP_BUILD  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic KIND_PERLIN  = 1'b0;
  localparam logic KIND_SIMPLEX = 1'b1;

  localparam logic [1:0] CFG_SEED = 2'd0;
  localparam logic [1:0] CFG_KIND = 2'd1;

  typedef logic [PERM_AW-1:0] perm_addr_t;
  typedef logic [7:0]         perm_data_t;

  typedef struct packed {
    logic       we;
    perm_addr_t waddr;
    perm_data_t wdata;
    perm_addr_t raddr;
  } ram_req_t;

  function automatic logic signed [31:0] grad_dot(input logic [2:0] h,
                                                  input logic signed [31:0] dx,
                                                  input logic signed [31:0] dy);
    logic signed [31:0] g;
    unique case (h)
      3'd0: g = dx + dy;
      3'd1: g = dy - dx;
      3'd2: g = dx - dy;
      3'd3: g = -dx - dy;
      3'd4: g = dx;
      3'd5: g = -dx;
      3'd6: g = dy;
      3'd7: g = -dy;
      default: g = dx;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/gn2d_ram.sv
// gn2d_ram: generic single-port-write, single-port-read ram with registered read
module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/gn2d_shuf.sv
// gn2d_shuf: permutation table fill and lcg driven shuffle sequencer
module gn2d_shuf
  import gn2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] seed,
  input  perm_data_t  rdata,
  output ram_req_t    req,
  output logic        busy,
  output logic        done
);

  localparam logic [2:0] SH_IDLE = 3'd0;
  localparam logic [2:0] SH_FILL = 3'd1;
  localparam logic [2:0] SH_LCG  = 3'd2;
  localparam logic [2:0] SH_DIV  = 3'd3;
  localparam logic [2:0] SH_RDK  = 3'd4;
  localparam logic [2:0] SH_RDM  = 3'd5;
  localparam logic [2:0] SH_WRK  = 3'd6;
  localparam logic [2:0] SH_WRM  = 3'd7;

  logic [2:0]  sh_state_r, sh_state_nxt;
  perm_addr_t  cnt_r;
  logic        build_r;
  logic [31:0] lcg_r, dvd_r;
  perm_addr_t  k_r;
  logic [8:0]  rem_r, rem_nxt;
  logic [2:0]  dstep_r;
  perm_data_t  vk_r;
  logic [8:0]  divisor;
  logic [31:0] lcg_nxt;

  assign divisor = {1'b0, k_r} + 9'd1;
  assign lcg_nxt = lcg_r * LCG_MUL + LCG_ADD;

  // four dividend bits per cycle into the remainder, msb first
  always_comb begin
    logic [9:0] r;
    r = {1'b0, rem_r};
    for (int b = 0; b < 4; b++) begin
      r = {r[8:0], dvd_r[31 - b]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_nxt = r[8:0];
  end

  always_comb begin
    sh_state_nxt = sh_state_r;
    req          = '0;
    req.raddr    = k_r;
    unique case (sh_state_r)
      SH_IDLE: if (start) sh_state_nxt = SH_FILL;
      SH_FILL: begin
        req.we    = 1'b1;
        req.waddr = cnt_r;
        req.wdata = cnt_r;
        if (cnt_r == '1) sh_state_nxt = build_r ? SH_LCG : SH_IDLE;
      end
      SH_LCG:  sh_state_nxt = SH_DIV;
      SH_DIV:  if (dstep_r == 3'd7) sh_state_nxt = SH_RDK;
      SH_RDK: begin
        req.raddr    = k_r;
        sh_state_nxt = SH_RDM;
      end
      SH_RDM: begin
        req.raddr    = rem_r[PERM_AW-1:0];
        sh_state_nxt = SH_WRK;
      end
      SH_WRK: begin
        req.we       = 1'b1;
        req.waddr    = k_r;
        req.wdata    = rdata;
        sh_state_nxt = SH_WRM;
      end
      SH_WRM: begin
        req.we       = 1'b1;
        req.waddr    = rem_r[PERM_AW-1:0];
        req.wdata    = vk_r;
        sh_state_nxt = (k_r == perm_addr_t'(1)) ? SH_IDLE : SH_LCG;
      end
      default: sh_state_nxt = SH_IDLE;
    endcase
  end

  assign busy = (sh_state_r != SH_IDLE);
  assign done = (sh_state_r == SH_WRM) && (k_r == perm_addr_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_state_r <= SH_FILL;
      cnt_r      <= '0;
      build_r    <= 1'b0;
    end else begin
      sh_state_r <= sh_state_nxt;
      if (sh_state_r == SH_FILL) cnt_r <= cnt_r + perm_addr_t'(1);
      if (sh_state_r == SH_IDLE && start) begin
        cnt_r   <= '0;
        build_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (sh_state_r)
      SH_IDLE: begin
        lcg_r <= (seed == 32'd0) ? SEED_DEFAULT : seed;
        k_r   <= '1;
      end
      SH_LCG: begin
        lcg_r   <= lcg_nxt;
        dvd_r   <= lcg_nxt;
        rem_r   <= '0;
        dstep_r <= '0;
      end
      SH_DIV: begin
        rem_r   <= rem_nxt;
        dvd_r   <= {dvd_r[27:0], 4'd0};
        dstep_r <= dstep_r + 3'd1;
      end
      SH_RDM:  vk_r <= rdata;
      SH_WRM:  k_r  <= k_r - perm_addr_t'(1);
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/gn2d_eval.sv
// gn2d_eval: sample sequencer with table lookups and a shared fixed point multiplier
module gn2d_eval
  import gn2d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               kind,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  perm_data_t         rdata,
  output perm_addr_t         raddr,
  output logic               done,
  output logic signed [15:0] result
);

  localparam int SH = QB - FRAC_BITS;
  localparam int IW = 34 - FRAC_BITS;
  localparam int TW = IW + 24;
  localparam int WW = 37 + SH;

  localparam logic [3:0] EV_IDLE = 4'd0;
  localparam logic [3:0] EV_SK1  = 4'd1;
  localparam logic [3:0] EV_SK2  = 4'd2;
  localparam logic [3:0] EV_SK3  = 4'd3;
  localparam logic [3:0] EV_SK4  = 4'd4;
  localparam logic [3:0] EV_SK5  = 4'd5;
  localparam logic [3:0] EV_RD   = 4'd6;
  localparam logic [3:0] EV_MA   = 4'd7;
  localparam logic [3:0] EV_MB   = 4'd8;
  localparam logic [3:0] EV_FIN  = 4'd9;

  logic [3:0] ev_state_r, ev_state_nxt;

  logic signed [31:0] x_r, y_r;
  logic               kind_r;
  logic signed [56:0] skp_r;
  logic signed [IW-1:0] i_r, j_r;
  logic signed [TW-1:0] tg_r;
  logic signed [31:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic               i1_r;
  perm_data_t         slot_r [6];
  logic [2:0]         step_r;
  logic [3:0]         op_r;
  logic [1:0]         crn_r;
  logic signed [31:0] mul_a_r, mul_b_r;
  logic               nz_r;
  logic signed [39:0] ta_r, tb_r, acc_r;
  logic signed [31:0] u_r, v_r, r1_r, r2_r;

  // skew front end
  logic signed [32:0] sum_xy;
  logic signed [32:0] skew_s;
  logic signed [33:0] xs, ys;
  logic signed [IW:0] ij;
  logic signed [WW-1:0] x0w, y0w;

  assign sum_xy = 33'(x_r) + 33'(y_r);
  assign skew_s = skp_r[56:24];
  assign xs     = 34'(x_r) + 34'(skew_s);
  assign ys     = 34'(y_r) + 34'(skew_s);
  assign ij     = (IW+1)'(i_r) + (IW+1)'(j_r);
  assign x0w    = (WW'(x_r) <<< SH) - (WW'(i_r) <<< QB) + WW'(tg_r);
  assign y0w    = (WW'(y_r) <<< SH) - (WW'(j_r) <<< QB) + WW'(tg_r);

  // perlin cell offsets
  logic signed [31:0] xf0, yf0, xf1, yf1;
  perm_addr_t xi0, yi0, ii, jj;

  assign xf0 = 32'(x_r[FRAC_BITS-1:0]) << SH;
  assign yf0 = 32'(y_r[FRAC_BITS-1:0]) << SH;
  assign xf1 = xf0 - ONE_Q;
  assign yf1 = yf0 - ONE_Q;
  assign xi0 = x_r[FRAC_BITS +: PERM_AW];
  assign yi0 = y_r[FRAC_BITS +: PERM_AW];
  assign ii  = i_r[PERM_AW-1:0];
  assign jj  = j_r[PERM_AW-1:0];

  always_comb begin
    raddr = xi0;
    if (kind_r == KIND_PERLIN) begin
      unique case (step_r)
        3'd0:    raddr = xi0;
        3'd1:    raddr = xi0 + perm_addr_t'(1);
        3'd2:    raddr = slot_r[0] + yi0;
        3'd3:    raddr = slot_r[0] + yi0 + perm_addr_t'(1);
        3'd4:    raddr = slot_r[1] + yi0;
        default: raddr = slot_r[1] + yi0 + perm_addr_t'(1);
      endcase
    end else begin
      unique case (step_r)
        3'd0:    raddr = jj;
        3'd1:    raddr = jj + perm_addr_t'(!i1_r);
        3'd2:    raddr = jj + perm_addr_t'(1);
        3'd3:    raddr = ii + slot_r[0];
        3'd4:    raddr = ii + perm_addr_t'(i1_r) + slot_r[1];
        default: raddr = ii + perm_addr_t'(1) + slot_r[2];
      endcase
    end
  end

  // gradients
  logic signed [31:0] gaa, gab, gba, gbb;
  logic signed [31:0] cdx, cdy, cg;
  perm_data_t         ch;

  assign gaa = grad_dot(slot_r[2][2:0], xf0, yf0);
  assign gab = grad_dot(slot_r[3][2:0], xf0, yf1);
  assign gba = grad_dot(slot_r[4][2:0], xf1, yf0);
  assign gbb = grad_dot(slot_r[5][2:0], xf1, yf1);

  always_comb begin
    unique case (crn_r)
      2'd0: begin
        cdx = x0_r; cdy = y0_r; ch = slot_r[3];
      end
      2'd1: begin
        cdx = x1_r; cdy = y1_r; ch = slot_r[4];
      end
      default: begin
        cdx = x2_r; cdy = y2_r; ch = slot_r[5];
      end
    endcase
  end
  assign cg = grad_dot(ch[2:0], cdx, cdy);

  // falloff before the square
  logic signed [41:0] tfall;
  assign tfall = 42'(HALF_Q) - 42'(ta_r) - 42'(tb_r);

  logic signed [31:0] opa, opb;
  always_comb begin
    opa = xf0;
    opb = xf0;
    if (kind_r == KIND_PERLIN) begin
      unique case (op_r)
        4'd0: begin opa = (xf0 <<< 2) + (xf0 <<< 1) - FIFTEEN_Q; opb = xf0; end
        4'd1: begin opa = xf0; opb = xf0; end
        4'd2: begin opa = tb_r[31:0]; opb = xf0; end
        4'd3: begin opa = tb_r[31:0]; opb = ta_r[31:0] + TEN_Q; end
        4'd4: begin opa = (yf0 <<< 2) + (yf0 <<< 1) - FIFTEEN_Q; opb = yf0; end
        4'd5: begin opa = yf0; opb = yf0; end
        4'd6: begin opa = tb_r[31:0]; opb = yf0; end
        4'd7: begin opa = tb_r[31:0]; opb = ta_r[31:0] + TEN_Q; end
        4'd8: begin opa = gba - gaa; opb = u_r; end
        4'd9: begin opa = gbb - gab; opb = u_r; end
        default: begin opa = r2_r - r1_r; opb = v_r; end
      endcase
    end else begin
      unique case (op_r)
        4'd0: begin opa = cdx; opb = cdx; end
        4'd1: begin opa = cdy; opb = cdy; end
        4'd2: begin opa = tfall[31:0]; opb = tfall[31:0]; end
        4'd3: begin opa = ta_r[31:0]; opb = ta_r[31:0]; end
        default: begin opa = ta_r[31:0]; opb = cg; end
      endcase
    end
  end

  logic signed [63:0] prod;
  logic signed [39:0] pq;
  logic               last_op;

  assign prod    = 64'(mul_a_r) * 64'(mul_b_r);
  assign pq      = prod[63:24];
  assign last_op = (kind_r == KIND_PERLIN) ? (op_r == 4'd10)
                                           : (op_r == 4'd4 && crn_r == 2'd2);

  // final scale, round to q2.14 and saturate
  logic signed [47:0] qv;
  logic signed [37:0] rq;
  always_comb begin
    logic signed [47:0] a;
    a  = 48'(acc_r);
    qv = (kind_r == KIND_SIMPLEX) ? (a <<< 6) + (a <<< 2) + (a <<< 1) : a;
    rq = 38'((qv + 48'sd512) >>> 10);
    if (rq > 38'sd32767) begin
      result = 16'sd32767;
    end else if (rq < -38'sd32768) begin
      result = -16'sd32768;
    end else begin
      result = rq[15:0];
    end
  end

  assign done = (ev_state_r == EV_FIN);

  always_comb begin
    ev_state_nxt = ev_state_r;
    unique case (ev_state_r)
      EV_IDLE: if (start) ev_state_nxt = (kind == KIND_SIMPLEX) ? EV_SK1 : EV_RD;
      EV_SK1:  ev_state_nxt = EV_SK2;
      EV_SK2:  ev_state_nxt = EV_SK3;
      EV_SK3:  ev_state_nxt = EV_SK4;
      EV_SK4:  ev_state_nxt = EV_SK5;
      EV_SK5:  ev_state_nxt = EV_RD;
      EV_RD:   if (step_r == 3'd6) ev_state_nxt = EV_MA;
      EV_MA:   ev_state_nxt = EV_MB;
      EV_MB:   ev_state_nxt = last_op ? EV_FIN : EV_MA;
      EV_FIN:  ev_state_nxt = EV_IDLE;
      default: ev_state_nxt = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_state_r <= EV_IDLE;
    end else begin
      ev_state_r <= ev_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ev_state_r)
      EV_IDLE: begin
        x_r    <= x_coord;
        y_r    <= y_coord;
        kind_r <= kind;
        step_r <= '0;
        op_r   <= '0;
        crn_r  <= '0;
        acc_r  <= '0;
      end
      EV_SK1: skp_r <= 57'(sum_xy) * 57'(SKEW_F2);
      EV_SK2: begin
        i_r <= IW'(xs >>> FRAC_BITS);
        j_r <= IW'(ys >>> FRAC_BITS);
      end
      EV_SK3: tg_r <= TW'(ij) * TW'(SKEW_G2);
      EV_SK4: begin
        x0_r <= x0w[31:0];
        y0_r <= y0w[31:0];
      end
      EV_SK5: begin
        i1_r <= (x0_r > y0_r);
        x1_r <= x0_r - ((x0_r > y0_r) ? ONE_Q : 32'sd0) + 32'(SKEW_G2);
        y1_r <= y0_r - ((x0_r > y0_r) ? 32'sd0 : ONE_Q) + 32'(SKEW_G2);
        x2_r <= x0_r - ONE_Q + (32'(SKEW_G2) <<< 1);
        y2_r <= y0_r - ONE_Q + (32'(SKEW_G2) <<< 1);
      end
      EV_RD: begin
        step_r <= step_r + 3'd1;
        if (step_r != 3'd0) slot_r[3'(step_r - 3'd1)] <= rdata;
      end
      EV_MA: begin
        mul_a_r <= opa;
        mul_b_r <= opb;
        if (kind_r == KIND_SIMPLEX && op_r == 4'd2) nz_r <= (tfall > 42'sd0);
      end
      EV_MB: begin
        if (kind_r == KIND_PERLIN) begin
          op_r <= op_r + 4'd1;
          unique case (op_r)
            4'd0, 4'd4: ta_r <= pq;
            4'd1, 4'd2, 4'd5, 4'd6: tb_r <= pq;
            4'd3: u_r  <= pq[31:0];
            4'd7: v_r  <= pq[31:0];
            4'd8: r1_r <= gaa + pq[31:0];
            4'd9: r2_r <= gab + pq[31:0];
            default: acc_r <= 40'(r1_r) + pq;
          endcase
        end else begin
          if (op_r == 4'd4) begin
            op_r  <= '0;
            crn_r <= crn_r + 2'd1;
          end else begin
            op_r <= op_r + 4'd1;
          end
          unique case (op_r)
            4'd0, 4'd2, 4'd3: ta_r <= pq;
            4'd1: tb_r <= pq;
            default: if (nz_r) acc_r <= acc_r + pq;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/gradient_noise_2d.sv
// Seeded 2d gradient noise, perlin or simplex, with a 256-entry permutation table in ram.
// Each sample's run is set by six dependent table reads and one shared multiplier stepped
// through its operations in turn; a build does 256 fill writes, then 255 swaps. One
// transaction is in work at a time and the next can be taken in the same cycle that
// out_valid rises.
// Synchronous reset refills the table in identity order with in_ready low.
module gradient_noise_2d
  import gn2d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_noise_value,
  output logic               out_was_build,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] seed_r;
  logic        kind_r;
  logic        out_valid_r;
  logic signed [15:0] out_val_r, res_val_r;
  logic        out_build_r, res_build_r;

  logic        in_fire, out_free;
  logic        sh_start, sh_busy, sh_done;
  logic        ev_start, ev_done;
  logic signed [15:0] ev_result;
  ram_req_t    sh_req;
  perm_addr_t  ev_raddr, ram_raddr;
  perm_data_t  ram_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE) && !sh_busy;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign sh_start  = in_fire && (in_opcode == OP_BUILD);
  assign ev_start  = in_fire && (in_opcode == OP_SAMPLE);
  assign ram_raddr = sh_busy ? sh_req.raddr : ev_raddr;

  gn2d_ram #(
    .WIDTH (8),
    .DEPTH (256)
  ) u_perm (
    .clk   (clk),
    .we    (sh_req.we),
    .waddr (sh_req.waddr),
    .wdata (sh_req.wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gn2d_shuf u_shuf (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sh_start),
    .seed  (seed_r),
    .rdata (ram_rdata),
    .req   (sh_req),
    .busy  (sh_busy),
    .done  (sh_done)
  );

  gn2d_eval #(
    .FRAC_BITS (FRAC_BITS)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ev_start),
    .kind    (kind_r),
    .x_coord (in_x_coord),
    .y_coord (in_y_coord),
    .rdata   (ram_rdata),
    .raddr   (ev_raddr),
    .done    (ev_done),
    .result  (ev_result)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sh_start) state_nxt = ST_BUILD;
        else if (ev_start) state_nxt = ST_EVAL;
      end
      ST_BUILD: if (sh_done) state_nxt = ST_HOLD;
      ST_EVAL:  if (ev_done) state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      kind_r      <= KIND_PERLIN;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SEED: seed_r <= cfg_data;
          CFG_KIND: kind_r <= cfg_data[0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_BUILD && sh_done) begin
      res_val_r   <= '0;
      res_build_r <= 1'b1;
    end else if (state_r == ST_EVAL && ev_done) begin
      res_val_r   <= ev_result;
      res_build_r <= 1'b0;
    end
    if (state_r == ST_HOLD && out_free) begin
      out_val_r   <= res_val_r;
      out_build_r <= res_build_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_val_r;
  assign out_was_build   = out_build_r;

endmodule

FILE: rtl/core/gn2d_checker.sv
// gn2d_checker: port level assertions for the 2d noise block, bound to the top level
module gn2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_noise_value,
  input logic        out_was_build
);

  // stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value) && $stable(out_was_build))
    else $error("result changed while stalled");

  // build acknowledgements carry a zero value
  a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_build |-> out_noise_value == 16'd0)
    else $error("build result with nonzero value");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_noise_value (out_noise_value),
  .out_was_build   (out_was_build)
);

FILE: tb/testbench.sv
// testbench for gradient_noise_2d: directed and random items checked against a local noise model
`timescale 1ns / 1ps

module testbench;
  import gn2d_pkg::*;

  localparam int FRAC    = 16;
  localparam int WD_LIMIT = 40000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = OP_SAMPLE;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_noise_value;
  logic               out_was_build;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_SEED;
  logic [31:0]        cfg_data = '0;

  gradient_noise_2d #(.FRAC_BITS(FRAC)) DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // local copy of block state
  logic [7:0]  perm_copy [256];
  logic [31:0] seed_reg;
  logic        kind_reg;

  typedef struct {
    logic signed [15:0] noise;
    logic               build;
  } noise_result_t;

  noise_result_t expected_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_errors = 0;
  int n_samples, n_builds, n_cfg;
  int quiet_cycles = 0;

  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> QB;
  endfunction

  function automatic logic [7:0] perm_at(longint idx);
    return perm_copy[idx[7:0]];
  endfunction

  function automatic longint gdot(logic [2:0] h, longint dx, longint dy);
    case (h)
      3'd0: return dx + dy;
      3'd1: return dy - dx;
      3'd2: return dx - dy;
      3'd3: return -dx - dy;
      3'd4: return dx;
      3'd5: return -dx;
      3'd6: return dy;
      default: return -dy;
    endcase
  endfunction

  function automatic longint quintic(longint t);
    longint p;
    p = 6 * t - 15 * longint'(ONE_Q);
    p = fmul(p, t) + 10 * longint'(ONE_Q);
    return fmul(fmul(fmul(t, t), t), p);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + fmul(b - a, w);
  endfunction

  function automatic longint perlin_value(logic [31:0] xr, logic [31:0] yr);
    longint xi0, yi0, xf0, yf0, xf1, yf1, u, v, r1, r2;
    logic [7:0] aa, ab, ba, bb;
    logic [31:0] fmask;
    fmask = (32'd1 << FRAC) - 1;
    xi0 = (xr >> FRAC) & 255;
    yi0 = (yr >> FRAC) & 255;
    xf0 = longint'(xr & fmask) << (QB - FRAC);
    yf0 = longint'(yr & fmask) << (QB - FRAC);
    xf1 = xf0 - ONE_Q;
    yf1 = yf0 - ONE_Q;
    u = quintic(xf0);
    v = quintic(yf0);
    aa = perm_at(perm_at(xi0) + yi0);
    ab = perm_at(perm_at(xi0) + yi0 + 1);
    ba = perm_at(perm_at(xi0 + 1) + yi0);
    bb = perm_at(perm_at(xi0 + 1) + yi0 + 1);
    r1 = blend(gdot(aa[2:0], xf0, yf0), gdot(ba[2:0], xf1, yf0), u);
    r2 = blend(gdot(ab[2:0], xf0, yf1), gdot(bb[2:0], xf1, yf1), u);
    return blend(r1, r2, v);
  endfunction

  function automatic longint corner(longint dx, longint dy, logic [2:0] h);
    longint t;
    t = longint'(HALF_Q) - fmul(dx, dx) - fmul(dy, dy);
    if (t <= 0) return 0;
    t = fmul(t, t);
    t = fmul(t, t);
    return fmul(t, gdot(h, dx, dy));
  endfunction

  function automatic longint simplex_value(longint x, longint y);
    longint s, i, j, t, x0, y0, x1, y1, x2, y2, i1, j1, ii, jj, sum;
    logic [7:0] h0, h1, h2;
    s = ((x + y) * longint'(SKEW_F2)) >>> QB;
    i = (x + s) >>> FRAC;
    j = (y + s) >>> FRAC;
    t = (i + j) * longint'(SKEW_G2);
    x0 = x * (longint'(1) << (QB - FRAC)) - i * ONE_Q + t;
    y0 = y * (longint'(1) << (QB - FRAC)) - j * ONE_Q + t;
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    x1 = x0 - i1 * ONE_Q + SKEW_G2;
    y1 = y0 - j1 * ONE_Q + SKEW_G2;
    x2 = x0 - ONE_Q + 2 * longint'(SKEW_G2);
    y2 = y0 - ONE_Q + 2 * longint'(SKEW_G2);
    ii = i & 255;
    jj = j & 255;
    h0 = perm_at(ii + perm_at(jj));
    h1 = perm_at(ii + i1 + perm_at(jj + j1));
    h2 = perm_at(ii + 1 + perm_at(jj + 1));
    sum = corner(x0, y0, h0[2:0]) + corner(x1, y1, h1[2:0]) + corner(x2, y2, h2[2:0]);
    return 70 * sum;
  endfunction

  task automatic shuffle_table();
    logic [31:0] st;
    logic [31:0] m;
    logic [7:0]  tmp;
    st = (seed_reg != 0) ? seed_reg : SEED_DEFAULT;
    for (int k = 0; k < 256; k++) perm_copy[k] = k[7:0];
    for (int k = 255; k > 0; k--) begin
      st = st * LCG_MUL + LCG_ADD;
      m = st % (k + 1);
      tmp = perm_copy[k];
      perm_copy[k] = perm_copy[m[7:0]];
      perm_copy[m[7:0]] = tmp;
    end
  endtask

  task automatic predict_noise(logic op, logic signed [31:0] x, logic signed [31:0] y);
    noise_result_t r;
    longint q, v;
    if (op == OP_BUILD) begin
      shuffle_table();
      r.noise = '0;
      r.build = 1'b1;
      n_builds++;
    end else begin
      q = (kind_reg == KIND_SIMPLEX) ? simplex_value(longint'(x), longint'(y))
                                     : perlin_value(x, y);
      v = (q + 512) >>> 10;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r.noise = v[15:0];
      r.build = 1'b0;
      n_samples++;
    end
    expected_q.push_back(r);
  endtask

  task automatic send_item(logic op, logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (!in_ready);
    predict_noise(op, x, y);
  endtask

  // drain everything in flight, then write one register
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx == CFG_SEED) seed_reg = data;
    else if (idx == CFG_KIND) kind_reg = data[0];
  endtask

  function automatic logic signed [31:0] rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return $urandom;
    if (sel == 3) return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(70000)
                                           : 32'sh80000000 + $urandom_range(70000);
    return $signed($urandom_range(32'h3fffff)) - 32'sh200000;
  endfunction

  task automatic test_directed();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_item(OP_SAMPLE, 0, 0);
    send_item(OP_SAMPLE, 32'sh7fffffff, 32'sh7fffffff);
    send_item(OP_SAMPLE, 32'sh80000000, 32'sh80000000);
    send_item(OP_SAMPLE, 32'sh7fffffff, 32'sh80000000);
    send_item(OP_SAMPLE, -1, -1);
    send_item(OP_SAMPLE, 32'sh00ff8000, 32'sh00ffffff);
    // seed zero falls back to the default constant
    send_item(OP_BUILD, 0, 0);
    send_item(OP_SAMPLE, 32'sh00018000, 32'shfffe4000);
    write_reg(CFG_KIND, 32'(KIND_SIMPLEX));
    send_item(OP_SAMPLE, 0, 0);
    send_item(OP_SAMPLE, 32'sh7fffffff, 32'sh80000000);
    send_item(OP_SAMPLE, 32'sh80000000, 32'sh7fffffff);
    send_item(OP_SAMPLE, 32'sh00008000, 32'sh00004000);
    send_item(OP_SAMPLE, 32'sh00004000, 32'sh00008000);
    send_item(OP_SAMPLE, -32'sh00012345, 32'sh00031111);
    write_reg(CFG_SEED, 32'hffffffff);
    send_item(OP_BUILD, 32'shffffffff, 32'shffffffff);
    send_item(OP_SAMPLE, 32'sh00050000, 32'sh00050000);
    // index outside the register list is ignored
    write_reg(2'd2, 32'h1);
    write_reg(2'd3, 32'h0);
    send_item(OP_SAMPLE, 32'sh00030000, 32'sh00020000);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 2) send_item(OP_BUILD, $urandom, $urandom);
      else send_item(OP_SAMPLE, rand_coord(), rand_coord());
    end
  endtask

  task automatic test_perlin_random();
    write_reg(CFG_KIND, 32'(KIND_PERLIN));
    write_reg(CFG_SEED, $urandom);
    random_phase(250, 0, 0);
    random_phase(250, 49, 0);
    random_phase(250, 0, 49);
    random_phase(250, 25, 25);
  endtask

  task automatic test_simplex_random();
    write_reg(CFG_KIND, 32'(KIND_SIMPLEX));
    write_reg(CFG_SEED, 32'h00000001);
    send_item(OP_BUILD, 0, 0);
    random_phase(250, 0, 0);
    random_phase(250, 49, 0);
    write_reg(CFG_SEED, $urandom);
    random_phase(250, 0, 49);
    random_phase(250, 25, 25);
  endtask

  task automatic test_seed_sweep();
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_SEED, (k == 0) ? 32'h0 : $urandom);
      write_reg(CFG_KIND, 32'(k[0]));
      send_item(OP_BUILD, 0, 0);
      random_phase(20, 25, 25);
    end
  endtask

  // result checker, receiver stalls and watchdog
  always @(posedge clk) begin
    noise_result_t e;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               WD_LIMIT, expected_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result noise=%0d build=%0b",
                                     out_noise_value, out_was_build);
      end else begin
        e = expected_q.pop_front();
        if (e.noise !== out_noise_value || e.build !== out_was_build) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected noise=%0d build=%0b, got noise=%0d build=%0b",
                     e.noise, e.build, out_noise_value, out_was_build);
        end
      end
    end
  end

  initial begin
    send_idle_pct = 0; recv_stall_pct = 0;
    n_samples = 0; n_builds = 0; n_cfg = 0;
    seed_reg = '0; kind_reg = KIND_PERLIN;
    for (int k = 0; k < 256; k++) perm_copy[k] = k[7:0];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_perlin_random();
    test_simplex_random();
    test_seed_sweep();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d samples, %0d table builds, %0d register writes", n_samples,
             n_builds, n_cfg);
    $display("perlin and simplex, several seeds, with and without idle and stall; %0d errors",
             n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
